### hdl/set_assoc_cache_lru_sim_macros.svh
// Assertion macros shared by the cache simulator RTL.
`ifndef SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SACL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/sacl_pkg.sv
// Shared types and constants of the cache simulator.
package sacl_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 64;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int OUTCOME_W  = 2;
    localparam int TOTAL_W    = 32;
    localparam int SB_W       = 4;

    // Access kind that counts one extra hit.
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOOK = 1'b1
    } t_state;

    // Result of one set lookup.
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } t_lookup_status;

endpackage

### hdl/sacl_row_mem.sv
// Synchronous single-write, single-read row memory with registered read data.
module sacl_row_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/sacl_set_logic.sv
// Tag match, victim choice and LRU age update for one set row.
module sacl_set_logic
    import sacl_pkg::*;
#(
    parameter int MAX_WAYS = 8,
    parameter int AGE_W    = 3,
    parameter int WAY_W    = 3,
    parameter int WAYS_CW  = 4
) (
    input  logic                              i_row_ok,
    input  logic [MAX_WAYS*(AGE_W+1)-1:0]     i_meta,
    input  logic [MAX_WAYS*ADDR_W-1:0]        i_tags,
    input  logic [ADDR_W-1:0]                 i_tag,
    input  logic [WAYS_CW-1:0]                i_ways,
    output logic [MAX_WAYS*(AGE_W+1)-1:0]     o_meta,
    output logic [MAX_WAYS*ADDR_W-1:0]        o_tags,
    output t_lookup_status                    o_status
);

    localparam int AGE_XW = AGE_W + 1;
    localparam logic [AGE_W-1:0]  AGE_MAX   = AGE_W'(MAX_WAYS - 1);
    localparam logic [AGE_XW-1:0] LIMIT_ALL = AGE_XW'(MAX_WAYS);

    logic [MAX_WAYS-1:0] valid;
    logic [MAX_WAYS-1:0] in_use;
    logic [AGE_W-1:0]    age   [MAX_WAYS];
    logic [ADDR_W-1:0]   tag_w [MAX_WAYS];

    logic              hit_found;
    logic              empty_found;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  empty_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  target;
    logic [AGE_XW-1:0] limit;

    // Unpack the row; a row never written reads as all invalid with zero ages.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            valid[w]  = i_row_ok & i_meta[w*AGE_XW + AGE_W];
            age[w]    = i_row_ok ? i_meta[w*AGE_XW +: AGE_W] : '0;
            tag_w[w]  = i_tags[w*ADDR_W +: ADDR_W];
            in_use[w] = (WAYS_CW'(w) < i_ways);
        end
    end

    // Search the ways in use: first matching way, first empty way, oldest way.
    always_comb begin
        hit_found   = 1'b0;
        empty_found = 1'b0;
        hit_way     = '0;
        empty_way   = '0;
        victim      = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w]) begin
                if (valid[w]) begin
                    if (!hit_found && (tag_w[w] == i_tag)) begin
                        hit_found = 1'b1;
                        hit_way   = WAY_W'(w);
                    end
                    if ((age[w] > age[victim]) || !valid[victim]) begin
                        victim = WAY_W'(w);
                    end
                end else if (!empty_found) begin
                    empty_found = 1'b1;
                    empty_way   = WAY_W'(w);
                end
            end
        end
    end

    // Pick the way that becomes most recent and the age limit for the others.
    always_comb begin
        o_status.hit   = hit_found;
        o_status.fill  = !hit_found && empty_found;
        o_status.evict = !hit_found && !empty_found;
        if (hit_found) begin
            target = hit_way;
            limit  = {1'b0, age[hit_way]};
        end else if (empty_found) begin
            target = empty_way;
            limit  = LIMIT_ALL;
        end else begin
            target = victim;
            limit  = {1'b0, age[victim]};
        end
    end

    // Build the row to write back.
    always_comb begin
        logic             nv;
        logic [AGE_W-1:0] na;
        for (int w = 0; w < MAX_WAYS; w++) begin
            nv = valid[w];
            na = age[w];
            if (in_use[w] && valid[w] && ({1'b0, age[w]} < limit) && (age[w] < AGE_MAX)) begin
                na = age[w] + 1'b1;
            end
            if (WAY_W'(w) == target) begin
                nv = 1'b1;
                na = '0;
            end
            o_meta[w*AGE_XW +: AGE_XW] = {nv, na};
            o_tags[w*ADDR_W +: ADDR_W] =
                (!hit_found && (WAY_W'(w) == target)) ? i_tag : tag_w[w];
        end
    end

endmodule

### hdl/set_assoc_cache_lru_sim.sv
// Top level of the tag-only set-associative cache simulator with LRU replacement.
//
// Usage:
//   Access channel: i_in_valid / o_in_ready carry i_mode and i_address. Each
//   transfer is one data access and produces exactly one result.
//   Result channel: o_out_valid / i_out_ready carry o_outcome and the running
//   hit, miss and eviction totals as they stand after that access.
//   Configuration channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; always ready. Write only while no access is in flight.
//   Timing: an access reads its set row from the tag and state memories in the
//   cycle it is taken and updates the row in the next cycle unless the output
//   register is still full; the result is registered with the row update. One
//   access is in flight at a time: a new access is taken only once the previous
//   one has finished the read-modify-write of its set row.
//   Stalls: a result waits in the output register while the receiver holds
//   i_out_ready low; the next access is still taken, and its row update waits
//   until the output register is free.
//   Reset: i_rst_n low clears all counters, set and offset bits, per-set row
//   flags (every line reads invalid) and sets one way; no clearing pass is needed.
`include "set_assoc_cache_lru_sim_macros.svh"

module set_assoc_cache_lru_sim
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Access channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [ADDR_W-1:0]     i_address,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUTCOME_W-1:0]  o_outcome,
    output logic [TOTAL_W-1:0]    o_hit_total,
    output logic [TOTAL_W-1:0]    o_miss_total,
    output logic [TOTAL_W-1:0]    o_eviction_total,
    // Configuration channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_AW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SET_MW    = SET_AW + 1;
    localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W     = AGE_W;
    localparam int WAYS_CW   = $clog2(MAX_WAYS + 1);
    localparam int META_W    = MAX_WAYS * (AGE_W + 1);
    localparam int TAGS_W    = MAX_WAYS * ADDR_W;
    localparam int SHIFT_W   = 7;
    localparam int WCLAMP_W  = 5;
    localparam int SUM_W     = COUNT_WIDTH + 1;

    // Configuration registers.
    logic [2:0]              r_set_bits;
    logic [3:0]              r_ways;
    logic [CFG_DATA_W-1:0]   r_offset_bits;

    // Control and access registers.
    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    t_outcome                r_outcome;
    logic [MODE_W-1:0]       r_mode;
    logic [ADDR_W-1:0]       r_tag;
    logic [SET_AW-1:0]       r_set;
    logic                    r_rd_row_ok;
    logic [NUM_SETS-1:0]     r_row_init;
    logic [COUNT_WIDTH-1:0]  r_hit_count, n_hit_count;
    logic [COUNT_WIDTH-1:0]  r_miss_count, n_miss_count;
    logic [COUNT_WIDTH-1:0]  r_eviction_count, n_eviction_count;

    logic                    w_in_xfer;
    logic                    w_finish;
    logic [SB_W-1:0]         w_eff_sb;
    logic [WCLAMP_W-1:0]     w_ways_raw;
    logic [WCLAMP_W-1:0]     w_ways_clamp;
    logic [WAYS_CW-1:0]      w_eff_ways;
    logic [ADDR_W-1:0]       w_shifted;
    logic [SET_MW-1:0]       w_set_mask;
    logic [SET_AW-1:0]       w_set;
    logic [SHIFT_W-1:0]      w_tag_shift;
    logic [ADDR_W-1:0]       w_tag;
    logic [META_W-1:0]       w_meta_rd, w_meta_wr;
    logic [TAGS_W-1:0]       w_tags_rd, w_tags_wr;
    t_lookup_status          w_status;
    logic [1:0]              w_hit_inc;
    logic [SUM_W-1:0]        w_hit_sum, w_miss_sum, w_evict_sum;

    // Configuration writes; the port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_ways        <= 4'd1;
            r_offset_bits <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data[2:0];
                CFG_WAYS:        r_ways        <= i_cfg_data[3:0];
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // Effective set bits and ways after clamping to the built capacity; zero ways counts as one.
    assign w_eff_sb = ({1'b0, r_set_bits} > SB_W'(MAX_SET_BITS)) ?
                      SB_W'(MAX_SET_BITS) : {1'b0, r_set_bits};
    assign w_ways_raw = {1'b0, r_ways};

    always_comb begin
        if (w_ways_raw == '0) begin
            w_ways_clamp = WCLAMP_W'(1);
        end else if (w_ways_raw > WCLAMP_W'(MAX_WAYS)) begin
            w_ways_clamp = WCLAMP_W'(MAX_WAYS);
        end else begin
            w_ways_clamp = w_ways_raw;
        end
    end

    assign w_eff_ways = WAYS_CW'(w_ways_clamp);

    // Address split; shifts of 64 or more give zero.
    assign w_shifted   = i_address >> r_offset_bits;
    assign w_set_mask  = (SET_MW'(1) << w_eff_sb) - SET_MW'(1);
    assign w_set       = w_shifted[SET_AW-1:0] & w_set_mask[SET_AW-1:0];
    assign w_tag_shift = SHIFT_W'(r_offset_bits) + SHIFT_W'(w_eff_sb);
    assign w_tag       = i_address >> w_tag_shift;

    // Sequencer: take an access, then update its row once the output is free.
    assign w_in_xfer = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_out_valid || i_out_ready) begin
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the access fields along with the memory read.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mode <= i_mode;
            r_tag  <= w_tag;
            r_set  <= w_set;
        end
    end

    // Per-set flags mark rows that hold written data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_init  <= '0;
            r_rd_row_ok <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_rd_row_ok <= r_row_init[w_set];
            end
            if (w_finish) begin
                r_row_init[r_set] <= 1'b1;
            end
        end
    end

    // Valid bits and ages of each set.
    sacl_row_mem #(
        .WIDTH (META_W),
        .DEPTH (NUM_SETS),
        .AW    (SET_AW)
    ) u_meta_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_xfer),
        .i_rd_addr (w_set),
        .o_rd_data (w_meta_rd),
        .i_wr_en   (w_finish),
        .i_wr_addr (r_set),
        .i_wr_data (w_meta_wr)
    );

    // Tags of each set.
    sacl_row_mem #(
        .WIDTH (TAGS_W),
        .DEPTH (NUM_SETS),
        .AW    (SET_AW)
    ) u_tag_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_xfer),
        .i_rd_addr (w_set),
        .o_rd_data (w_tags_rd),
        .i_wr_en   (w_finish),
        .i_wr_addr (r_set),
        .i_wr_data (w_tags_wr)
    );

    // Lookup and replacement on the row just read.
    sacl_set_logic #(
        .MAX_WAYS (MAX_WAYS),
        .AGE_W    (AGE_W),
        .WAY_W    (WAY_W),
        .WAYS_CW  (WAYS_CW)
    ) u_set_logic (
        .i_row_ok (r_rd_row_ok),
        .i_meta   (w_meta_rd),
        .i_tags   (w_tags_rd),
        .i_tag    (r_tag),
        .i_ways   (w_eff_ways),
        .o_meta   (w_meta_wr),
        .o_tags   (w_tags_wr),
        .o_status (w_status)
    );

    // Saturating counters; a modify adds one extra hit.
    assign w_hit_inc   = {1'b0, w_status.hit} + {1'b0, (r_mode == MODE_MODIFY)};
    assign w_hit_sum   = {1'b0, r_hit_count} + SUM_W'(w_hit_inc);
    assign w_miss_sum  = {1'b0, r_miss_count} + SUM_W'(!w_status.hit);
    assign w_evict_sum = {1'b0, r_eviction_count} + SUM_W'(w_status.evict);

    always_comb begin
        n_hit_count      = r_hit_count;
        n_miss_count     = r_miss_count;
        n_eviction_count = r_eviction_count;
        if (w_finish) begin
            n_hit_count      = w_hit_sum[COUNT_WIDTH] ? '1 : w_hit_sum[COUNT_WIDTH-1:0];
            n_miss_count     = w_miss_sum[COUNT_WIDTH] ? '1 : w_miss_sum[COUNT_WIDTH-1:0];
            n_eviction_count = w_evict_sum[COUNT_WIDTH] ? '1 : w_evict_sum[COUNT_WIDTH-1:0];
        end
    end

    // Output register flag: set by a finished access, cleared by a transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_hit_count      <= '0;
            r_miss_count     <= '0;
            r_eviction_count <= '0;
        end else begin
            r_out_valid      <= n_out_valid;
            r_hit_count      <= n_hit_count;
            r_miss_count     <= n_miss_count;
            r_eviction_count <= n_eviction_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            if (w_status.hit) begin
                r_outcome <= OUT_HIT;
            end else if (w_status.fill) begin
                r_outcome <= OUT_FILL;
            end else begin
                r_outcome <= OUT_EVICT;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_outcome;
    assign o_hit_total      = TOTAL_W'(r_hit_count);
    assign o_miss_total     = TOTAL_W'(r_miss_count);
    assign o_eviction_total = TOTAL_W'(r_eviction_count);

    // A row update never overwrites a result that is still waiting.
    `SACL_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_state == ST_LOOK && r_out_valid && !i_out_ready, r_state == ST_LOOK)
    // Exactly one outcome per finished lookup.
    `SACL_ASSERT_SAME(a_one_outcome, i_clk, i_rst_n, w_finish, $onehot(w_status))
    // The miss counter moves only when an access completes.
    `SACL_ASSERT_NEXT(a_miss_quiet, i_clk, i_rst_n, !w_finish, $stable(r_miss_count))
    // The hit count never goes down.
    `SACL_ASSERT_NEXT(a_hit_monotonic, i_clk, i_rst_n, 1'b1, r_hit_count >= $past(r_hit_count))

endmodule

### verif/set_assoc_cache_lru_sim_test.sv
// Self-checking testbench for the set-associative cache simulator with LRU replacement.
`timescale 1ns / 100ps

module set_assoc_cache_lru_sim_test;
    import sacl_pkg::*;

    localparam int MAX_SET_BITS     = 6;
    localparam int MAX_WAYS         = 8;
    localparam int COUNT_WIDTH      = 32;
    localparam int NUM_SETS         = 1 << MAX_SET_BITS;
    localparam int AGE_TOP          = MAX_WAYS - 1;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int STALL_LIMIT      = 2000;
    localparam int PRINT_LIMIT      = 100;

    // Access kinds that the package does not name.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        t_outcome            outcome;
        logic [TOTAL_W-1:0]  hits;
        logic [TOTAL_W-1:0]  misses;
        logic [TOTAL_W-1:0]  evictions;
    } t_cache_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [MODE_W-1:0]     i_mode;
    logic [ADDR_W-1:0]     i_address;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [OUTCOME_W-1:0]  o_outcome;
    logic [TOTAL_W-1:0]    o_hit_total;
    logic [TOTAL_W-1:0]    o_miss_total;
    logic [TOTAL_W-1:0]    o_eviction_total;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predicted cache contents, counters and register settings.
    bit                    cached_valid [NUM_SETS][MAX_WAYS];
    logic [ADDR_W-1:0]     cached_tag   [NUM_SETS][MAX_WAYS];
    bit [2:0]              cached_age   [NUM_SETS][MAX_WAYS];
    logic [TOTAL_W-1:0]    tally_hits;
    logic [TOTAL_W-1:0]    tally_misses;
    logic [TOTAL_W-1:0]    tally_evictions;
    logic [2:0]            cfg_set_bits;
    logic [3:0]            cfg_ways;
    logic [5:0]            cfg_offset_bits;

    t_cache_result         expected_results[$];
    int                    mismatches;
    int                    idle_cycles;
    bit                    tx_burst;
    bit                    rx_burst;
    bit                    long_hold_req;

    set_assoc_cache_lru_sim #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_mode(i_mode),
        .i_address(i_address),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_outcome(o_outcome),
        .o_hit_total(o_hit_total),
        .o_miss_total(o_miss_total),
        .o_eviction_total(o_eviction_total),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [MODE_W-1:0] random_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return MODE_LOAD;
        if (r < 7) return MODE_STORE;
        if (r < 9) return MODE_MODIFY;
        return MODE_SPARE;
    endfunction

    // A register value in the useful range, or now and then any 6-bit pattern.
    function automatic logic [CFG_DATA_W-1:0] random_setting(input int hi);
        if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, 63));
        return CFG_DATA_W'($urandom_range(0, hi));
    endfunction

    function automatic int eff_set_bits();
        return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
    endfunction

    function automatic int eff_ways();
        if (cfg_ways == 0) return 1;
        if (cfg_ways > MAX_WAYS) return MAX_WAYS;
        return int'(cfg_ways);
    endfunction

    function automatic logic [TOTAL_W-1:0] bump_count(input logic [TOTAL_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Builds an address from tag, set and offset under the current settings.
    function automatic logic [ADDR_W-1:0] compose_address(input logic [ADDR_W-1:0] tag,
                                                          input int set_idx,
                                                          input logic [ADDR_W-1:0] offset);
        logic [127:0] wide;
        logic [127:0] set_wide;
        int sb;
        int bb;
        sb = eff_set_bits();
        bb = int'(cfg_offset_bits);
        set_wide = 128'(set_idx & ((1 << sb) - 1));
        wide = ({64'd0, tag} << (bb + sb)) | (set_wide << bb)
             | ({64'd0, offset} & ((128'd1 << bb) - 128'd1));
        return wide[ADDR_W-1:0];
    endfunction

    // Valid ways in use that are younger than the limit grow one step older.
    function automatic void age_younger(input int set_idx, input int nways, input int limit);
        for (int w = 0; w < nways; w++) begin
            if (cached_valid[set_idx][w] && int'(cached_age[set_idx][w]) < limit
                && int'(cached_age[set_idx][w]) < AGE_TOP) begin
                cached_age[set_idx][w]++;
            end
        end
    endfunction

    // Lookup, fill or eviction for one access, and the totals after it.
    function automatic t_cache_result predict_access(input logic [MODE_W-1:0] mode,
                                                     input logic [ADDR_W-1:0] addr);
        t_cache_result     res;
        int                sb;
        int                nways;
        int                bb;
        int                set_idx;
        int                hit_way;
        int                empty_way;
        int                victim;
        logic [ADDR_W-1:0] tag;
        sb = eff_set_bits();
        nways = eff_ways();
        bb = int'(cfg_offset_bits);
        set_idx = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
        tag = addr >> (bb + sb);
        hit_way = -1;
        empty_way = -1;
        victim = 0;

        for (int w = 0; w < nways; w++) begin
            if (cached_valid[set_idx][w]) begin
                if (hit_way < 0 && cached_tag[set_idx][w] == tag) hit_way = w;
                if (cached_age[set_idx][w] > cached_age[set_idx][victim]
                    || !cached_valid[set_idx][victim]) begin
                    victim = w;
                end
            end else if (empty_way < 0) begin
                empty_way = w;
            end
        end

        if (hit_way >= 0) begin
            age_younger(set_idx, nways, int'(cached_age[set_idx][hit_way]));
            cached_age[set_idx][hit_way] = '0;
            tally_hits = bump_count(tally_hits);
            res.outcome = OUT_HIT;
        end else if (empty_way >= 0) begin
            age_younger(set_idx, nways, AGE_TOP + 1);
            cached_valid[set_idx][empty_way] = 1'b1;
            cached_tag[set_idx][empty_way] = tag;
            cached_age[set_idx][empty_way] = '0;
            tally_misses = bump_count(tally_misses);
            res.outcome = OUT_FILL;
        end else begin
            age_younger(set_idx, nways, int'(cached_age[set_idx][victim]));
            cached_tag[set_idx][victim] = tag;
            cached_age[set_idx][victim] = '0;
            tally_misses = bump_count(tally_misses);
            tally_evictions = bump_count(tally_evictions);
            res.outcome = OUT_EVICT;
        end

        // A modify counts one more hit on top of its own outcome.
        if (mode == MODE_MODIFY) tally_hits = bump_count(tally_hits);

        res.hits = tally_hits;
        res.misses = tally_misses;
        res.evictions = tally_evictions;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) $display("%0t ns: %s", $time, what);
    endtask

    // Offers one access after a random gap and records its prediction on transfer.
    task automatic send_access(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = tx_burst ? 0 : idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_address <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_access(mode, addr));
    endtask

    // Stops offering accesses until every predicted result has arrived.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_SET_BITS:    cfg_set_bits = data[2:0];
            CFG_WAYS:        cfg_ways = data[3:0];
            CFG_OFFSET_BITS: cfg_offset_bits = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset settings: one way, one set, the whole address is the tag.
    task automatic test_reset_defaults();
        send_access(MODE_LOAD, '0);
        send_access(MODE_STORE, '0);
        send_access(MODE_MODIFY, '1);
        send_access(MODE_SPARE, '1);
    endtask

    // Out-of-range set bits and ways, the widest offset, and an unused index.
    task automatic test_config_extremes();
        logic [ADDR_W-1:0] tag;
        wait_for_results();
        write_config(CFG_SET_BITS, 6'd7);
        write_config(CFG_WAYS, 6'd15);
        write_config(CFG_OFFSET_BITS, 6'd63);
        send_access(MODE_LOAD, 64'h0000_0000_0000_0000);
        send_access(MODE_STORE, 64'h8000_0000_0000_0000);
        send_access(MODE_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(MODE_SPARE, 64'h7FFF_FFFF_FFFF_FFFF);
        wait_for_results();
        write_config(CFG_SPARE, random_setting(63));
        write_config(CFG_SET_BITS, 6'b111_110);
        write_config(CFG_WAYS, 6'd0);
        write_config(CFG_OFFSET_BITS, 6'd32);
        tag = rand64();
        send_access(MODE_LOAD, compose_address(tag, 9, rand64()));
        send_access(MODE_MODIFY, compose_address(tag, 9, rand64()));
    endtask

    // Fills into the lowest empty way, a hit, then evictions of the least recent way.
    task automatic test_lru_order();
        logic [ADDR_W-1:0] tags[5];
        wait_for_results();
        write_config(CFG_SET_BITS, 6'd3);
        write_config(CFG_WAYS, 6'd4);
        write_config(CFG_OFFSET_BITS, 6'd4);
        foreach (tags[k]) tags[k] = rand64();
        for (int k = 0; k < 4; k++) send_access(random_mode(), compose_address(tags[k], 5, rand64()));
        send_access(MODE_LOAD, compose_address(tags[0], 5, rand64()));
        send_access(MODE_STORE, compose_address(tags[4], 5, rand64()));
        send_access(MODE_LOAD, compose_address(tags[1], 5, rand64()));
    endtask

    // Shrinking and growing the ways leaves two copies of one tag with equal
    // ages: the lower way must hit, and the lower way must go on a tie.
    task automatic test_duplicate_tags();
        logic [ADDR_W-1:0] tag_x;
        logic [ADDR_W-1:0] tag_y;
        logic [ADDR_W-1:0] tag_z;
        tag_x = rand64();
        tag_y = rand64();
        tag_z = rand64();
        wait_for_results();
        write_config(CFG_SET_BITS, 6'd6);
        write_config(CFG_OFFSET_BITS, 6'd0);
        write_config(CFG_WAYS, 6'd1);
        send_access(MODE_LOAD, compose_address(tag_x, 45, '0));
        wait_for_results();
        write_config(CFG_WAYS, 6'd2);
        send_access(MODE_STORE, compose_address(tag_y, 45, '0));
        wait_for_results();
        write_config(CFG_WAYS, 6'd1);
        send_access(MODE_LOAD, compose_address(tag_y, 45, '0));
        wait_for_results();
        write_config(CFG_WAYS, 6'd2);
        send_access(MODE_MODIFY, compose_address(tag_y, 45, '0));
        send_access(MODE_LOAD, compose_address(tag_z, 45, '0));
    endtask

    // The receiver holds off for a long stretch while accesses keep coming.
    task automatic test_output_backpressure();
        wait_for_results();
        long_hold_req = 1'b1;
        tx_burst = 1'b1;
        repeat (16) begin
            send_access(random_mode(),
                        compose_address(ADDR_W'($urandom_range(0, 3)), $urandom_range(0, 3),
                                        rand64()));
        end
        tx_burst = 1'b0;
    endtask

    // One setting, a small pool of tags over a few sets, and some noise.
    task automatic run_traffic_phase(input logic [CFG_DATA_W-1:0] set_bits,
                                     input logic [CFG_DATA_W-1:0] ways,
                                     input logic [CFG_DATA_W-1:0] offset_bits,
                                     input int n_items);
        logic [ADDR_W-1:0] tag_pool[$];
        int                set_pool[$];
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] addr;
        wait_for_results();
        write_config(CFG_SET_BITS, set_bits);
        write_config(CFG_WAYS, ways);
        write_config(CFG_OFFSET_BITS, offset_bits);
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        repeat (eff_ways() + $urandom_range(0, 3)) begin
            tag = $urandom_range(0, 1) ? rand64() : ADDR_W'($urandom_range(0, 7));
            tag_pool.push_back(tag);
        end
        repeat ($urandom_range(1, 3)) set_pool.push_back($urandom_range(0, (1 << eff_set_bits()) - 1));
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                addr = compose_address(tag_pool[$urandom_range(0, tag_pool.size() - 1)],
                                       set_pool[$urandom_range(0, set_pool.size() - 1)],
                                       rand64());
            end else begin
                addr = rand64();
            end
            send_access(random_mode(), addr);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(6'd7, 6'd8, 6'd0, 61);
        run_traffic_phase(6'd0, 6'd1, 6'd63, 61);
        run_traffic_phase(6'd6, 6'd15, 6'd32, 61);
        run_traffic_phase(6'd2, 6'd0, 6'd5, 61);
        repeat (6) run_traffic_phase(random_setting(7), random_setting(15), random_setting(12), 61);
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode <= MODE_LOAD;
        i_address <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SET_BITS;
        i_cfg_data <= '0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        long_hold_req = 1'b0;
        tally_hits = '0;
        tally_misses = '0;
        tally_evictions = '0;
        cfg_set_bits = '0;
        cfg_ways = 4'd1;
        cfg_offset_bits = '0;
        foreach (cached_valid[s, w]) begin
            cached_valid[s][w] = 1'b0;
            cached_tag[s][w] = '0;
            cached_age[s][w] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_lru_order();
        test_duplicate_tags();
        test_output_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result receiver: random stalls, or one long hold when asked for.
    initial begin : result_receiver
        int hold;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            hold = 0;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end else if (!rx_burst) begin
                hold = idle_gap();
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Each result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_cache_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result arrived with no access outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_outcome != want.outcome)
                    report_mismatch($sformatf("outcome %0d, expected %0d",
                                              o_outcome, want.outcome));
                if (o_hit_total != want.hits)
                    report_mismatch($sformatf("hit total %0d, expected %0d",
                                              o_hit_total, want.hits));
                if (o_miss_total != want.misses)
                    report_mismatch($sformatf("miss total %0d, expected %0d",
                                              o_miss_total, want.misses));
                if (o_eviction_total != want.evictions)
                    report_mismatch($sformatf("eviction total %0d, expected %0d",
                                              o_eviction_total, want.evictions));
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
